/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for RTL that checks its own logic, used by the sorter top.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PARS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PARS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pars_pkg.sv */
// ---------------------------------------------------------------------------
// pars_pkg
// Types and constants for the per-axis point rank sorter.
// ---------------------------------------------------------------------------
package pars_pkg;

	localparam int MAX_POINTS = 64;
	localparam int MAX_DIMS   = 8;

	localparam int SLOT_W  = $clog2(MAX_POINTS);
	localparam int AXIS_W  = $clog2(MAX_DIMS);
	localparam int ADDR_W  = SLOT_W + AXIS_W;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int DCNT_W  = $clog2(MAX_DIMS + 1);
	localparam int COORD_W = 32;
	localparam int ID_W    = 16;
	localparam int CFG_W   = (CNT_W > DCNT_W) ? CNT_W : DCNT_W;

	// Configuration register indexes
	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_DIM_COUNT   = 1'b1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic                      mode;
		logic [SLOT_W-1:0]         slot;
		logic [AXIS_W-1:0]         axis;
		logic signed [COORD_W-1:0] coord_value;
		logic [ID_W-1:0]           point_id;
		logic [SLOT_W-1:0]         rank;
		logic                      last_load;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] sorted_id;
		logic            status;
	} result_t;

	// Coordinate store write from the load path
	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [COORD_W-1:0] data;
	} coord_wr_t;

	// Order table write from the sort sequencer
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [SLOT_W-1:0] slot;
	} ord_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PIVOT,
		ST_SCAN,
		ST_WRITE
	} sort_state_t;

endpackage

/* rtl/pars_rank_unit.sv */
// ---------------------------------------------------------------------------
// pars_rank_unit
// Coordinate store and rank sequencer. For each axis and each pivot point it
// scans all points through one shared comparator, counts those that order
// before the pivot, and writes the pivot slot at that rank.
// ---------------------------------------------------------------------------
module pars_rank_unit import pars_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  coord_wr_t         coord_wr,
	input  logic              sort_start,
	input  logic [CNT_W-1:0]  point_count,
	input  logic [DCNT_W-1:0] dim_count,
	output logic              sort_busy,
	output ord_wr_t           ord_wr
);

	logic [COORD_W-1:0] coord_mem [MAX_POINTS*MAX_DIMS];
	logic [COORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]  rd_addr;

	sort_state_t        state_q, state_nxt;
	logic [AXIS_W-1:0]  axis_q;
	logic [SLOT_W-1:0]  i_q;
	logic [CNT_W-1:0]   j_q;
	logic [SLOT_W-1:0]  pos_q;
	logic [COORD_W-1:0] ci_q;

	logic [SLOT_W-1:0]  j_cmp;
	logic               hit;
	logic               last_i;
	logic               last_axis;
	logic               scan_done;

	always_ff @(posedge clk) begin
		if (coord_wr.en) begin
			coord_mem[coord_wr.addr] <= coord_wr.data;
		end
		rd_data_q <= coord_mem[rd_addr];
	end

	// Fetch the pivot first, then stream every point of the axis
	assign rd_addr = (state_q == ST_FETCH) ? {i_q, axis_q} : {j_q[SLOT_W-1:0], axis_q};

	// Shared compare: point j_cmp orders before the pivot (ties by slot)
	assign j_cmp = SLOT_W'(j_q - CNT_W'(1));
	assign hit   = ($signed(rd_data_q) < $signed(ci_q)) ||
	               ((rd_data_q == ci_q) && (j_cmp < i_q));

	assign scan_done = (j_q == point_count);
	assign last_i    = (CNT_W'({1'b0, i_q}) + CNT_W'(1)) == point_count;
	assign last_axis = (DCNT_W'({1'b0, axis_q}) + DCNT_W'(1)) == dim_count;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (sort_start) state_nxt = ST_FETCH;
			ST_FETCH: state_nxt = ST_PIVOT;
			ST_PIVOT: state_nxt = ST_SCAN;
			ST_SCAN:  if (scan_done) state_nxt = ST_WRITE;
			ST_WRITE: state_nxt = (last_i && last_axis) ? ST_IDLE : ST_FETCH;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ord_wr      = '0;
		ord_wr.addr = {axis_q, pos_q};
		ord_wr.slot = i_q;
		sort_busy   = (state_q != ST_IDLE);
		case (state_q)
			ST_WRITE: ord_wr.en = 1'b1;
			default:  ord_wr.en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
					i_q    <= '0;
				end
				ST_FETCH: begin
					j_q   <= '0;
					pos_q <= '0;
				end
				ST_PIVOT: j_q <= j_q + CNT_W'(1);
				ST_SCAN: begin
					j_q <= j_q + CNT_W'(1);
					if (hit) begin
						pos_q <= pos_q + SLOT_W'(1);
					end
				end
				ST_WRITE: begin
					// advance to the next pivot, or the next axis
					if (last_i) begin
						i_q    <= '0;
						axis_q <= axis_q + AXIS_W'(1);
					end else begin
						i_q <= i_q + SLOT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PIVOT) begin
			ci_q <= rd_data_q;
		end
	end

endmodule

/* rtl/per_axis_point_rank_sorter.sv */
// ---------------------------------------------------------------------------
// per_axis_point_rank_sorter
// Loads point coordinates, ranks the points along every axis in use, and
// answers queries for the point id at a given axis and rank.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears for
// one cycle with done high and cannot be held off. A load answers in the next
// cycle and busy stays low, so loads can follow each other every cycle. A
// query reads the order table and then the id store, one registered read
// each, and answers from the second read; busy is high in between.
// A load with last_load set answers in the next cycle and keeps busy high
// while the sort runs: each pivot point costs a pivot fetch, a scan of all
// points through the single comparator fed by the one coordinate memory
// read port, and an order table write. Equal coordinates rank by slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module per_axis_point_rank_sorter import pars_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output logic             done,
	output result_t          result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CNT_W-1:0]  point_count_q;
	logic [DCNT_W-1:0] dim_count_q;

	logic [ID_W-1:0]   id_mem  [MAX_POINTS];
	logic [SLOT_W-1:0] ord_mem [MAX_POINTS*MAX_DIMS];

	logic              accept;
	logic              is_load;
	logic              slot_bad;
	logic              axis_bad;
	logic              rank_bad;
	logic              load_ok;

	coord_wr_t         coord_wr;
	ord_wr_t           ord_wr;
	logic              sort_busy;

	logic              done_q;
	logic              ld_status_q;
	logic              act_s1, act_s2;
	logic              err_s1, err_s2;
	logic [SLOT_W-1:0] ord_s1;
	logic [ID_W-1:0]   id_s2;

	logic [CNT_W-1:0]  pc_wr;
	logic [DCNT_W-1:0] dc_wr;

	assign accept   = start && !busy;
	assign is_load  = (item.mode == MODE_LOAD);
	assign slot_bad = CNT_W'({1'b0, item.slot}) >= point_count_q;
	assign rank_bad = CNT_W'({1'b0, item.rank}) >= point_count_q;
	assign axis_bad = DCNT_W'({1'b0, item.axis}) >= dim_count_q;
	assign load_ok  = accept && is_load && !slot_bad && !axis_bad;

	assign busy = sort_busy || act_s1;

	// Saturate register writes to their legal range
	always_comb begin
		pc_wr = cfg_data[CNT_W-1:0];
		if (pc_wr == '0) begin
			pc_wr = CNT_W'(1);
		end else if (pc_wr > CNT_W'(MAX_POINTS)) begin
			pc_wr = CNT_W'(MAX_POINTS);
		end
		dc_wr = cfg_data[DCNT_W-1:0];
		if (dc_wr == '0) begin
			dc_wr = DCNT_W'(1);
		end else if (dc_wr > DCNT_W'(MAX_DIMS)) begin
			dc_wr = DCNT_W'(MAX_DIMS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(MAX_POINTS);
			dim_count_q   <= DCNT_W'(MAX_DIMS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= pc_wr;
				REG_DIM_COUNT:   dim_count_q   <= dc_wr;
				default: ;
			endcase
		end
	end

	always_comb begin
		coord_wr.en   = load_ok;
		coord_wr.addr = {item.slot, item.axis};
		coord_wr.data = item.coord_value;
	end

	pars_rank_unit u_rank (
		.clk         (clk),
		.arst_n      (arst_n),
		.coord_wr    (coord_wr),
		.sort_start  (accept && is_load && item.last_load),
		.point_count (point_count_q),
		.dim_count   (dim_count_q),
		.sort_busy   (sort_busy),
		.ord_wr      (ord_wr)
	);

	always_ff @(posedge clk) begin
		if (load_ok) begin
			id_mem[item.slot] <= item.point_id;
		end
		if (ord_wr.en) begin
			ord_mem[ord_wr.addr] <= ord_wr.slot;
		end
		ord_s1 <= ord_mem[{item.axis, item.rank}];
		id_s2  <= id_mem[ord_s1];
		err_s1 <= axis_bad || rank_bad;
		err_s2 <= err_s1;
		ld_status_q <= slot_bad || axis_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			done_q <= accept && is_load;
			act_s1 <= accept && !is_load;
			act_s2 <= act_s1;
		end
	end

	// Load results come from done_q, query results from the second read stage
	always_comb begin
		done = done_q || act_s2;
		if (act_s2) begin
			result.sorted_id = err_s2 ? '0 : id_s2;
			result.status    = err_s2;
		end else begin
			result.sorted_id = '0;
			result.status    = ld_status_q;
		end
	end

	`PARS_ASSERT(a_one_source, !(done_q && act_s2), "load and query results collide")
	`PARS_ASSERT_NEXT(a_sort_starts, accept && is_load && item.last_load, busy,
		"sort did not start after last load")
	`PARS_ASSERT_NEXT(a_query_answers, accept && !is_load, ##1 done,
		"query transaction produced no result")
	`PARS_ASSERT(a_ord_wr_busy, !ord_wr.en || busy, "order table written while idle")

endmodule

/* tb/sv/rank_table_monitor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rank_table_monitor
// Watches the item, result and register ports of the rank sorter, keeps its
// own copy of the coordinate, id and per-axis order tables, predicts the
// answer of every accepted transaction and compares it with what comes back.
// ---------------------------------------------------------------------------
module rank_table_monitor import pars_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  item_t            item,
	input  logic             done,
	input  result_t          result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               outstanding,
	output int               fail_count
);

	logic signed [COORD_W-1:0] coord_mem [MAX_POINTS*MAX_DIMS];
	logic [ID_W-1:0]           id_mem    [MAX_POINTS];
	logic [SLOT_W-1:0]         rank_slot [MAX_DIMS*MAX_POINTS];
	int unsigned               points_in_use;
	int unsigned               axes_in_use;
	result_t                   answer_queue [$];

	function automatic int unsigned clamp_points(input logic [CFG_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (32'(raw) > MAX_POINTS)
			return MAX_POINTS;
		return 32'(raw);
	endfunction

	function automatic int unsigned clamp_axes(input logic [CFG_W-1:0] raw);
		logic [3:0] nib;
		nib = raw[3:0];
		if (nib == '0)
			return 1;
		if (32'(nib) > MAX_DIMS)
			return MAX_DIMS;
		return 32'(nib);
	endfunction

	// Rank every point on every axis in use; equal coordinates rank by slot.
	function automatic void rebuild_rank_tables();
		int pos;
		logic signed [COORD_W-1:0] ci;
		logic signed [COORD_W-1:0] cj;
		for (int a = 0; a < axes_in_use; a++) begin
			for (int i = 0; i < points_in_use; i++) begin
				pos = 0;
				ci = coord_mem[i*MAX_DIMS + a];
				for (int j = 0; j < points_in_use; j++) begin
					cj = coord_mem[j*MAX_DIMS + a];
					if (j != i && (cj < ci || (cj == ci && j < i)))
						pos++;
				end
				rank_slot[a*MAX_POINTS + pos] = i[SLOT_W-1:0];
			end
		end
	endfunction

	function automatic result_t predict_answer(input item_t it);
		result_t ans;
		ans = '0;
		if (it.mode == MODE_LOAD) begin
			if (32'(it.slot) >= points_in_use || 32'(it.axis) >= axes_in_use) begin
				ans.status = 1'b1;
			end else begin
				coord_mem[it.slot*MAX_DIMS + it.axis] = it.coord_value;
				id_mem[it.slot] = it.point_id;
			end
			if (it.last_load)
				rebuild_rank_tables();
		end else begin
			if (32'(it.axis) >= axes_in_use || 32'(it.rank) >= points_in_use)
				ans.status = 1'b1;
			else
				ans.sorted_id = id_mem[rank_slot[it.axis*MAX_POINTS + it.rank]];
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int      errs;
		if (!arst_n) begin
			for (int k = 0; k < MAX_POINTS*MAX_DIMS; k++) begin
				coord_mem[k] = '0;
				rank_slot[k] = '0;
			end
			for (int k = 0; k < MAX_POINTS; k++)
				id_mem[k] = '0;
			points_in_use = MAX_POINTS;
			axes_in_use   = MAX_DIMS;
			answer_queue.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				if (cfg_index == REG_POINT_COUNT)
					points_in_use = clamp_points(cfg_data);
				else
					axes_in_use = clamp_axes(cfg_data);
			end
			if (start && !busy)
				answer_queue.push_back(predict_answer(item));
			if (done) begin
				if (answer_queue.size() == 0) begin
					$error("result transaction with no pending item: sorted_id %0h status %0b",
						result.sorted_id, result.status);
					errs++;
				end else begin
					want = answer_queue.pop_front();
					if (result.sorted_id !== want.sorted_id) begin
						$error("sorted_id mismatch: expected %0h, got %0h",
							want.sorted_id, result.sorted_id);
						errs++;
					end
					if (result.status !== want.status) begin
						$error("status mismatch: expected %0b, got %0b",
							want.status, result.status);
						errs++;
					end
				end
			end
			outstanding <= answer_queue.size();
			fail_count  <= fail_count + errs;
		end
	end

endmodule

/* tb/sv/per_axis_point_rank_sorter_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_axis_point_rank_sorter_tb
// Drives load and query transactions into the rank sorter under a series of
// point and axis counts, with random sender gaps, and leaves prediction and
// comparison to the monitor; reports the verdict at the end of the run.
// ---------------------------------------------------------------------------
module per_axis_point_rank_sorter_tb;
	import pars_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int ITEM_W      = $bits(item_t);

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_t            item;
	logic             done;
	result_t          result;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int outstanding;
	int fail_count;
	int cycle_count = 0;
	int idle_pct;

	per_axis_point_rank_sorter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rank_table_monitor u_rank_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mix wide random values with small ones and extremes to force ties.
	function automatic logic signed [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 3);
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $signed($urandom_range(0, 7)) - 4;
		endcase
	endfunction

	function automatic item_t make_load(input logic [SLOT_W-1:0] slot,
			input logic [AXIS_W-1:0] axis, input logic signed [COORD_W-1:0] coord,
			input logic [ID_W-1:0] pid, input logic last);
		item_t it;
		it.mode        = MODE_LOAD;
		it.slot        = slot;
		it.axis        = axis;
		it.coord_value = coord;
		it.point_id    = pid;
		it.rank        = SLOT_W'($urandom);
		it.last_load   = last;
		return it;
	endfunction

	function automatic item_t make_query(input logic [AXIS_W-1:0] axis,
			input logic [SLOT_W-1:0] rank);
		item_t it;
		it.mode        = MODE_QUERY;
		it.slot        = SLOT_W'($urandom);
		it.axis        = axis;
		it.coord_value = $urandom;
		it.point_id    = ID_W'($urandom);
		it.rank        = rank;
		it.last_load   = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Leave start high on return; the next call or settle() decides its level.
	task automatic send_item(input item_t it);
		logic [ITEM_W-1:0] junk;
		while ($urandom_range(0, 99) < idle_pct) begin
			junk = ITEM_W'({$urandom, $urandom, $urandom});
			start <= 1'b0;
			item  <= junk;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and wait until every answer is back and any sort has ended.
	task automatic settle();
		start <= 1'b0;
		do begin
			do
				@(posedge clk);
			while (outstanding != 0 || busy);
			repeat (3) @(posedge clk);
		end while (busy);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] pc_raw, input logic [CFG_W-1:0] dc_raw);
		logic dc_first;
		dc_first = 1'($urandom_range(0, 1));
		cfg_we    <= 1'b1;
		cfg_index <= dc_first ? REG_DIM_COUNT : REG_POINT_COUNT;
		cfg_data  <= dc_first ? dc_raw : pc_raw;
		@(posedge clk);
		cfg_index <= dc_first ? REG_POINT_COUNT : REG_DIM_COUNT;
		cfg_data  <= dc_first ? pc_raw : dc_raw;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int pc, input int dc, input logic [CFG_W-1:0] pc_raw,
			input logic [CFG_W-1:0] dc_raw, input int n_random, input int sort_odds,
			input int sort_cap);
		int   load_order [$];
		int   k;
		int   pick;
		int   tmp;
		int   sorts;
		logic want_sort;
		settle();
		apply_config(pc_raw, dc_raw);
		// Fill every slot and axis in use in random order; the final one sorts.
		for (k = 0; k < pc*dc; k++)
			load_order.push_back(k);
		for (k = pc*dc - 1; k > 0; k--) begin
			pick = $urandom_range(0, k);
			tmp = load_order[k];
			load_order[k] = load_order[pick];
			load_order[pick] = tmp;
		end
		for (k = 0; k < pc*dc; k++)
			send_item(make_load(SLOT_W'(load_order[k] / dc), AXIS_W'(load_order[k] % dc),
				random_coord(), ID_W'($urandom), k == pc*dc - 1));
		sorts = 0;
		for (k = 0; k < n_random; k++) begin
			pick = $urandom_range(0, 99);
			want_sort = (sorts < sort_cap) && ($urandom_range(0, sort_odds - 1) == 0);
			if (pick < 40) begin
				send_item(make_query(AXIS_W'($urandom_range(0, dc - 1)),
					SLOT_W'($urandom_range(0, pc - 1))));
			end else if (pick < 47) begin
				send_item(make_query(AXIS_W'($urandom_range(0, 7)),
					SLOT_W'($urandom_range(0, 63))));
			end else begin
				if (want_sort)
					sorts++;
				if (pick < 87)
					send_item(make_load(SLOT_W'($urandom_range(0, pc - 1)),
						AXIS_W'($urandom_range(0, dc - 1)),
						random_coord(), ID_W'($urandom), want_sort));
				else
					send_item(make_load(SLOT_W'($urandom_range(0, 63)),
						AXIS_W'($urandom_range(0, 7)),
						random_coord(), ID_W'($urandom), want_sort));
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_POINT_COUNT;
		cfg_data  <= '0;
		idle_pct  = 13;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three points on two axes; axis count written with stray upper bits.
		apply_config(7'd3, 7'h12);
		send_item(make_load(0, 0, 32'h7FFF_FFFF, 16'hFFFF, 1'b0));
		send_item(make_load(1, 0, 32'h8000_0000, 16'h0000, 1'b0));
		send_item(make_load(2, 0, 32'h7FFF_FFFF, 16'h1234, 1'b0));
		send_item(make_load(0, 1, 32'h0000_0000, 16'hFFFF, 1'b0));
		send_item(make_load(1, 1, 32'h0000_0000, 16'h0000, 1'b0));
		send_item(make_load(2, 1, 32'hFFFF_FFFF, 16'hA5A5, 1'b1));
		// Out-of-range loads store nothing.
		send_item(make_load(3, 0, 32'h1111_1111, 16'h3333, 1'b0));
		send_item(make_load(63, 7, 32'h2222_2222, 16'h4444, 1'b0));
		send_item(make_load(0, 2, 32'h3333_3333, 16'h5555, 1'b0));
		for (int a = 0; a < 2; a++)
			for (int r = 0; r < 3; r++)
				send_item(make_query(AXIS_W'(a), SLOT_W'(r)));
		send_item(make_query(0, 3));
		send_item(make_query(1, 63));
		send_item(make_query(2, 0));
		send_item(make_query(7, 63));
		// Reload a slot after the sort: the table keeps the slot, the id changes.
		send_item(make_load(1, 0, 32'h0000_0005, 16'h00FF, 1'b0));
		send_item(make_query(0, 0));
		// A rejected load still starts the sort.
		send_item(make_load(5, 1, 32'h4444_4444, 16'h6666, 1'b1));
		for (int r = 0; r < 3; r++)
			send_item(make_query(0, SLOT_W'(r)));

		run_phase(1, 1, 7'd0, 7'h70, 25, 10, 8);
		run_phase(64, 1, 7'd127, 7'd1, 25, 40, 3);

		idle_pct = 56;
		begin
			int pc;
			int dc;
			pc = $urandom_range(2, 12);
			dc = $urandom_range(2, 4);
			run_phase(pc, dc, CFG_W'(pc), {3'($urandom_range(0, 7)), dc[3:0]}, 25, 10, 8);
		end
		run_phase(4, 8, 7'd4, 7'h0F, 25, 10, 8);
		run_phase(16, 4, 7'd16, 7'h74, 25, 10, 4);

		idle_pct = 0;
		begin
			int pc;
			int dc;
			pc = $urandom_range(2, 12);
			dc = $urandom_range(1, 4);
			run_phase(pc, dc, CFG_W'(pc), {3'($urandom_range(0, 7)), dc[3:0]}, 25, 10, 8);
			pc = $urandom_range(20, 40);
			dc = $urandom_range(1, 2);
			run_phase(pc, dc, CFG_W'(pc), {3'($urandom_range(0, 7)), dc[3:0]}, 25, 10, 8);
		end

		settle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
